>>> rtl/gll_pkg.sv
// shared types, character constants and helpers for the gll sentence parser
`default_nettype none
package gll_pkg;

  localparam int FIELD_DEPTH_DEF = 12;

  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_G      = 8'h47;  // 'G'
  localparam logic [7:0] CH_P      = 8'h50;  // 'P'
  localparam logic [7:0] CH_L      = 8'h4C;  // 'L'
  localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','

  // result field codes; bits [2:1] of a text field select its memory bank
  typedef enum logic [2:0] {
    FLD_LAT    = 3'd0,
    FLD_NS     = 3'd1,
    FLD_LON    = 3'd2,
    FLD_EW     = 3'd3,
    FLD_TIME   = 3'd4,
    FLD_STATUS = 3'd5
  } field_id_t;

  typedef struct packed {
    logic       start;
    logic [7:0] status_char;
    logic [7:0] north_south;
    logic [7:0] east_west;
    logic       dropped;
  } gll_ctrl_t;

  // expected character for header states one to six ("GPGLL,")
  function automatic logic [7:0] header_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd1: ch = CH_G;
      3'd2: ch = CH_P;
      3'd3: ch = CH_G;
      3'd4: ch = CH_L;
      3'd5: ch = CH_L;
      3'd6: ch = CH_COMMA;
      default: ch = CH_DOLLAR;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

>>> rtl/gll_byte_if.sv
// valid/ready channel carrying one received character
`default_nettype none
interface gll_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/gll_result_if.sv
// valid/ready channel carrying one tagged result character
`default_nettype none
interface gll_result_if
  import gll_pkg::*;
#(
  parameter int FIELD_DEPTH = FIELD_DEPTH_DEF
);
  localparam int POS_W = $clog2(FIELD_DEPTH);
  localparam int LEN_W = $clog2(FIELD_DEPTH + 1);

  logic             valid;
  logic             ready;
  logic [2:0]       field_id;
  logic [POS_W-1:0] position;
  logic [7:0]       character;
  logic [LEN_W-1:0] field_length;
  logic             overflow;
  logic             last;

  modport source (output valid, output field_id, output position, output character,
                  output field_length, output overflow, output last, input ready);
  modport sink   (input valid, input field_id, input position, input character,
                  input field_length, input overflow, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/nmea_gll_sentence_parser.sv
// gll sentence parser: header matcher, field capture and burst playback
// the status character transfer starts the burst, which enters its read and load states
// each result then passes through memory read, load and transfer; transfer waits on output stalls
// while a burst plays out no character is taken; otherwise one character per cycle
// empty text fields are skipped in the read state of the burst without a transfer
// reset (rst, synchronous) returns to waiting for '$'; record memory is not cleared
`default_nettype none
module nmea_gll_sentence_parser
  import gll_pkg::*;
#(
  parameter int FIELD_DEPTH = FIELD_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  gll_byte_if.sink     char_stream,
  gll_result_if.source result_stream
);

  localparam int POS_W = $clog2(FIELD_DEPTH);
  localparam int LEN_W = $clog2(FIELD_DEPTH + 1);
  localparam int AW    = POS_W + 2;

  typedef enum logic [3:0] {
    S_IDLE      = 4'd0,
    S_HG1       = 4'd1,
    S_HP        = 4'd2,
    S_HG2       = 4'd3,
    S_HL1       = 4'd4,
    S_HL2       = 4'd5,
    S_HCOMMA    = 4'd6,
    S_LAT       = 4'd7,
    S_NS        = 4'd8,
    S_WAIT_LON  = 4'd9,
    S_LON       = 4'd10,
    S_EW        = 4'd11,
    S_WAIT_TIME = 4'd12,
    S_TIME      = 4'd13,
    S_STATUS    = 4'd14
  } parse_state_t;

  parse_state_t     state;
  logic [LEN_W-1:0] char_index;
  logic [LEN_W-1:0] lat_count;
  logic [LEN_W-1:0] lon_count;
  logic [LEN_W-1:0] time_count;
  logic [7:0]       north_south;
  logic [7:0]       east_west;
  logic             dropped;

  logic             accept;
  logic [7:0]       c;
  logic             busy;
  logic             cap_req;
  logic             fits;
  logic [1:0]       cap_bank;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  gll_ctrl_t        ctrl;

  assign c                 = char_stream.rx_byte;
  assign char_stream.ready = !busy;
  assign accept            = char_stream.valid && char_stream.ready;

  // text capture: any character but '$' and ',' in a text field
  assign cap_req = accept && (c != CH_DOLLAR) && (c != CH_COMMA) &&
                   ((state == S_LAT) || (state == S_LON) || (state == S_TIME));
  assign fits    = (char_index < LEN_W'(FIELD_DEPTH));
  assign wr_en   = cap_req && fits;

  always_comb begin
    case (state)
      S_LAT:   cap_bank = FLD_LAT[2:1];
      S_LON:   cap_bank = FLD_LON[2:1];
      default: cap_bank = FLD_TIME[2:1];
    endcase
  end

  assign wr_addr = {cap_bank, char_index[POS_W-1:0]};

  assign ctrl.start       = accept && (state == S_STATUS) && (c != CH_DOLLAR);
  assign ctrl.status_char = c;
  assign ctrl.north_south = north_south;
  assign ctrl.east_west   = east_west;
  assign ctrl.dropped     = dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      char_index  <= '0;
      lat_count   <= '0;
      lon_count   <= '0;
      time_count  <= '0;
      north_south <= '0;
      east_west   <= '0;
      dropped     <= 1'b0;
    end else if (accept) begin
      if ((state != S_IDLE) && (state <= S_STATUS) && (c == CH_DOLLAR)) begin
        state <= S_HG1;
      end else begin
        case (state)
          S_HG1, S_HP, S_HG2, S_HL1, S_HL2, S_HCOMMA: begin
            // a mismatch in the header holds the state
            if (c == header_char(state[2:0])) begin
              state <= parse_state_t'(state + 4'd1);
              if (state == S_HCOMMA) begin
                dropped    <= 1'b0;
                char_index <= '0;
                lat_count  <= '0;
              end
            end
          end
          S_LAT: begin
            if (c == CH_COMMA) begin
              state <= S_NS;
            end
          end
          S_NS: begin
            north_south <= c;
            state       <= S_WAIT_LON;
          end
          S_WAIT_LON: begin
            if (c == CH_COMMA) begin
              state      <= S_LON;
              char_index <= '0;
              lon_count  <= '0;
            end
          end
          S_LON: begin
            if (c == CH_COMMA) begin
              state <= S_EW;
            end
          end
          S_EW: begin
            east_west <= c;
            state     <= S_WAIT_TIME;
          end
          S_WAIT_TIME: begin
            if (c == CH_COMMA) begin
              state      <= S_TIME;
              char_index <= '0;
              time_count <= '0;
            end
          end
          S_TIME: begin
            if (c == CH_COMMA) begin
              state <= S_STATUS;
            end
          end
          S_STATUS: begin
            state      <= S_IDLE;
            char_index <= '0;
          end
          default: begin
            state <= (c == CH_DOLLAR) ? S_HG1 : S_IDLE;
          end
        endcase
        if (cap_req) begin
          if (fits) begin
            char_index <= char_index + LEN_W'(1);
            case (state)
              S_LAT:   lat_count  <= char_index + LEN_W'(1);
              S_LON:   lon_count  <= char_index + LEN_W'(1);
              default: time_count <= char_index + LEN_W'(1);
            endcase
          end else begin
            dropped <= 1'b1;
          end
        end
      end
    end
  end

  gll_burst #(
    .FIELD_DEPTH (FIELD_DEPTH)
  ) u_burst (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (c),
    .lat_count     (lat_count),
    .lon_count     (lon_count),
    .time_count    (time_count),
    .busy          (busy),
    .result_stream (result_stream)
  );

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(char_stream.ready && result_stream.valid))
    else $error("character taken while a burst is playing out");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    char_index <= LEN_W'(FIELD_DEPTH))
    else $error("capture index beyond field depth");

  a_burst_starts: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |=> !char_stream.ready)
    else $error("status character did not start a burst");

  a_counts_bound: assert property (@(posedge clk) disable iff (rst)
    (lat_count <= LEN_W'(FIELD_DEPTH)) && (lon_count <= LEN_W'(FIELD_DEPTH)) &&
    (time_count <= LEN_W'(FIELD_DEPTH)))
    else $error("field count beyond field depth");
`endif

endmodule
`default_nettype wire

>>> rtl/gll_burst.sv
// record memory and burst sequencer that plays a captured sentence out
`default_nettype none
module gll_burst
  import gll_pkg::*;
#(
  parameter int FIELD_DEPTH = FIELD_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire gll_ctrl_t                          ctrl,
  input  wire logic                               wr_en,
  input  wire logic [$clog2(FIELD_DEPTH)+1:0]     wr_addr,
  input  wire logic [7:0]                         wr_data,
  input  wire logic [$clog2(FIELD_DEPTH+1)-1:0]   lat_count,
  input  wire logic [$clog2(FIELD_DEPTH+1)-1:0]   lon_count,
  input  wire logic [$clog2(FIELD_DEPTH+1)-1:0]   time_count,
  output logic                                    busy,
  gll_result_if.source                            result_stream
);

  localparam int POS_W     = $clog2(FIELD_DEPTH);
  localparam int LEN_W     = $clog2(FIELD_DEPTH + 1);
  localparam int AW        = POS_W + 2;
  localparam int MEM_DEPTH = 3 * (2 ** POS_W);

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_LOAD,
    B_WAIT
  } burst_state_t;

  burst_state_t     bst;
  field_id_t        seg;
  logic [POS_W-1:0] pos;
  logic [7:0]       status_char;

  logic [7:0]       mem [0:MEM_DEPTH-1];
  logic [7:0]       rd_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;

  logic             seg_is_text;
  logic [LEN_W-1:0] seg_count;
  logic [7:0]       single_char;

  assign seg_is_text = !seg[0];
  assign busy        = (bst != B_IDLE);

  always_comb begin
    case (seg)
      FLD_LAT:  seg_count = lat_count;
      FLD_LON:  seg_count = lon_count;
      FLD_TIME: seg_count = time_count;
      default:  seg_count = LEN_W'(1);
    endcase
  end

  always_comb begin
    case (seg)
      FLD_NS:  single_char = ctrl.north_south;
      FLD_EW:  single_char = ctrl.east_west;
      default: single_char = status_char;
    endcase
  end

  assign rd_en   = (bst == B_READ) && seg_is_text && (seg_count != '0);
  assign rd_addr = {seg[2:1], pos};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bst                 <= B_IDLE;
      seg                 <= FLD_LAT;
      pos                 <= '0;
      result_stream.valid <= 1'b0;
    end else begin
      case (bst)
        B_IDLE: begin
          if (ctrl.start) begin
            status_char <= ctrl.status_char;
            seg         <= FLD_LAT;
            pos         <= '0;
            bst         <= B_READ;
          end
        end
        B_READ: begin
          // empty text fields are skipped without a transfer
          if (seg_is_text && (seg_count == '0)) begin
            seg <= field_id_t'(seg + 3'd1);
          end else begin
            bst <= B_LOAD;
          end
        end
        B_LOAD: begin
          result_stream.character    <= seg_is_text ? rd_data : single_char;
          result_stream.field_id     <= seg;
          result_stream.position     <= pos;
          result_stream.field_length <= seg_count;
          result_stream.overflow     <= ctrl.dropped;
          result_stream.last         <= (seg == FLD_STATUS);
          result_stream.valid        <= 1'b1;
          bst                        <= B_WAIT;
        end
        B_WAIT: begin
          if (result_stream.ready) begin
            result_stream.valid <= 1'b0;
            if (seg == FLD_STATUS) begin
              bst <= B_IDLE;
            end else if (seg_is_text && ((LEN_W'(pos) + LEN_W'(1)) < seg_count)) begin
              pos <= pos + POS_W'(1);
              bst <= B_READ;
            end else begin
              seg <= field_id_t'(seg + 3'd1);
              pos <= '0;
              bst <= B_READ;
            end
          end
        end
        default: bst <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> dv/tb.sv
// testbench for the gll sentence parser: byte stimulus, record prediction and burst checks
`default_nettype none
module tb;
  import gll_pkg::*;

  localparam int DEPTH       = FIELD_DEPTH_DEF;
  localparam int POS_W       = $clog2(DEPTH);
  localparam int LEN_W       = $clog2(DEPTH + 1);
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 20;

  // parser states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_HDR_FIRST = 4'd1;
  localparam logic [3:0] S_HDR_LAST  = 4'd6;
  localparam logic [3:0] S_LAT       = 4'd7;
  localparam logic [3:0] S_NS        = 4'd8;
  localparam logic [3:0] S_WAIT_LON  = 4'd9;
  localparam logic [3:0] S_LON       = 4'd10;
  localparam logic [3:0] S_EW        = 4'd11;
  localparam logic [3:0] S_WAIT_TIME = 4'd12;
  localparam logic [3:0] S_TIME      = 4'd13;
  localparam logic [3:0] S_STATUS    = 4'd14;

  localparam int BANK_LAT  = 0;
  localparam int BANK_LON  = 1;
  localparam int BANK_TIME = 2;

  typedef struct {
    field_id_t        fid;
    logic [POS_W-1:0] pos;
    logic [7:0]       ch;
    logic [LEN_W-1:0] len;
    logic             ovf;
    logic             last;
  } tagged_char_t;

  logic clk;
  logic rst;

  gll_byte_if                          chr_if ();
  gll_result_if #(.FIELD_DEPTH(DEPTH)) res_if ();

  nmea_gll_sentence_parser #(.FIELD_DEPTH(DEPTH)) u_top (
    .clk           (clk),
    .rst           (rst),
    .char_stream   (chr_if),
    .result_stream (res_if)
  );

  // predictor state
  logic [3:0]       p_state = S_IDLE;
  logic [LEN_W-1:0] text_idx = '0;
  logic [7:0]       text_mem [3][DEPTH];
  logic [LEN_W-1:0] text_cnt [3] = '{default: '0};
  logic [7:0]       ns_char = 8'h00;
  logic [7:0]       ew_char = 8'h00;
  logic             dropped = 1'b0;
  logic [7:0]       hdr_seq [1:6] = '{CH_G, CH_P, CH_G, CH_L, CH_L, CH_COMMA};

  logic [7:0]   rx_queue [$];
  tagged_char_t tagged_due [$];
  tagged_char_t want;

  int mismatches   = 0;
  int bytes_sent   = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int hold_left    = 0;
  bit held         = 0;

  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    mismatches++;
  endtask

  function automatic void push_tagged(input field_id_t f, input int pos, input logic [7:0] ch,
                                      input int len, input logic last);
    tagged_char_t t;
    t.fid  = f;
    t.pos  = pos[POS_W-1:0];
    t.ch   = ch;
    t.len  = len[LEN_W-1:0];
    t.ovf  = dropped;
    t.last = last;
    tagged_due.push_back(t);
  endfunction

  function automatic void push_field(input field_id_t f, input int bank);
    for (int i = 0; i < int'(text_cnt[bank]); i++)
      push_tagged(f, i, text_mem[bank][i], int'(text_cnt[bank]), 1'b0);
  endfunction

  function automatic void store_text(input int bank, input logic [7:0] c);
    if (text_idx < LEN_W'(DEPTH)) begin
      text_mem[bank][text_idx] = c;
      text_idx                 = text_idx + LEN_W'(1);
      text_cnt[bank]           = text_idx;
    end else begin
      dropped = 1'b1;
    end
  endfunction

  function automatic void open_field(input int bank);
    text_idx       = '0;
    text_cnt[bank] = '0;
  endfunction

  // advance the predicted parser by one accepted character
  function automatic void parse_char(input logic [7:0] c);
    if (p_state == S_IDLE || p_state > S_STATUS) begin
      p_state = (c == CH_DOLLAR) ? S_HDR_FIRST : S_IDLE;
    end else if (c == CH_DOLLAR) begin
      p_state = S_HDR_FIRST;
    end else if (p_state <= S_HDR_LAST) begin
      if (c == hdr_seq[p_state]) begin
        if (p_state == S_HDR_LAST) begin
          dropped = 1'b0;
          open_field(BANK_LAT);
        end
        p_state = p_state + 4'd1;
      end
    end else begin
      case (p_state)
        S_LAT: begin
          if (c == CH_COMMA) p_state = S_NS;
          else store_text(BANK_LAT, c);
        end
        S_NS: begin
          ns_char = c;
          p_state = S_WAIT_LON;
        end
        S_WAIT_LON: begin
          if (c == CH_COMMA) begin
            p_state = S_LON;
            open_field(BANK_LON);
          end
        end
        S_LON: begin
          if (c == CH_COMMA) p_state = S_EW;
          else store_text(BANK_LON, c);
        end
        S_EW: begin
          ew_char = c;
          p_state = S_WAIT_TIME;
        end
        S_WAIT_TIME: begin
          if (c == CH_COMMA) begin
            p_state = S_TIME;
            open_field(BANK_TIME);
          end
        end
        S_TIME: begin
          if (c == CH_COMMA) p_state = S_STATUS;
          else store_text(BANK_TIME, c);
        end
        default: begin
          p_state  = S_IDLE;
          text_idx = '0;
          push_field(FLD_LAT, BANK_LAT);
          push_tagged(FLD_NS, 0, ns_char, 1, 1'b0);
          push_field(FLD_LON, BANK_LON);
          push_tagged(FLD_EW, 0, ew_char, 1, 1'b0);
          push_field(FLD_TIME, BANK_TIME);
          push_tagged(FLD_STATUS, 0, c, 1, 1'b1);
        end
      endcase
    end
  endfunction

  // stimulus helpers
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_COMMA || b == CH_DOLLAR);
    return b;
  endfunction

  function automatic logic [7:0] flag_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_DOLLAR);
    return b;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(6);
    if (r < 85) return $urandom_range(DEPTH, 7);
    return $urandom_range(DEPTH + 4, DEPTH + 1);
  endfunction

  function automatic void add_text(ref logic [7:0] s [$], input int n);
    for (int i = 0; i < n; i++) s.push_back(text_byte());
  endfunction

  // junk before a separator comma is ignored by the parser
  function automatic void add_junk(ref logic [7:0] s [$]);
    int n;
    n = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
    for (int i = 0; i < n; i++) s.push_back(text_byte());
  endfunction

  // broken: 0 none, 1 overwrite a byte, 2 insert a dollar, 3 cut short
  function automatic void add_sentence(input int lat_n, input int lon_n, input int time_n,
                                       input int broken);
    logic [7:0] s [$];
    int         at;
    s = '{CH_DOLLAR, CH_G, CH_P, CH_G, CH_L, CH_L, CH_COMMA};
    add_text(s, lat_n);
    s.push_back(CH_COMMA);
    s.push_back($urandom_range(1) ? flag_byte() : ($urandom_range(1) ? "N" : "S"));
    add_junk(s);
    s.push_back(CH_COMMA);
    add_text(s, lon_n);
    s.push_back(CH_COMMA);
    s.push_back($urandom_range(1) ? flag_byte() : ($urandom_range(1) ? "E" : "W"));
    add_junk(s);
    s.push_back(CH_COMMA);
    add_text(s, time_n);
    s.push_back(CH_COMMA);
    s.push_back($urandom_range(1) ? flag_byte() : "A");
    at = $urandom_range(s.size() - 1, 1);
    case (broken)
      1: s[at] = 8'($urandom_range(255));
      2: s.insert(at, CH_DOLLAR);
      3: s = s[0:at-1];
      default: ;
    endcase
    foreach (s[i]) rx_queue.push_back(s[i]);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // character sender
  always @(posedge clk) begin
    if (rst) begin
      chr_if.valid   <= 1'b0;
      chr_if.rx_byte <= 8'h00;
    end else begin
      if (chr_if.valid && chr_if.ready) begin
        parse_char(chr_if.rx_byte);
        bytes_sent++;
      end
      if (!chr_if.valid || chr_if.ready) begin
        if (rx_queue.size() > 0 &&
            ((bytes_sent >= 80 && bytes_sent < 160) || $urandom_range(99) >= 35)) begin
          chr_if.valid   <= 1'b1;
          chr_if.rx_byte <= rx_queue.pop_front();
        end else begin
          chr_if.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: random stalls plus one long hold-off during a burst
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!held && results_seen >= 10) begin
      held         <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= (results_seen >= 30 && results_seen < 80) || $urandom_range(99) >= 35;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      results_seen <= results_seen + 1;
      if (tagged_due.size() == 0) begin
        report($sformatf("unexpected result: field %0d pos %0d char %02h",
                         res_if.field_id, res_if.position, res_if.character));
      end else begin
        want = tagged_due.pop_front();
        if (res_if.field_id !== want.fid || res_if.position !== want.pos ||
            res_if.character !== want.ch || res_if.field_length !== want.len ||
            res_if.overflow !== want.ovf || res_if.last !== want.last)
          report({$sformatf("result %0d: got f%0d p%0d c%02h n%0d o%b l%b",
                            results_seen, res_if.field_id, res_if.position,
                            res_if.character, res_if.field_length, res_if.overflow,
                            res_if.last),
                  $sformatf(", want f%0d p%0d c%02h n%0d o%b l%b",
                            want.fid, want.pos, want.ch, want.len, want.ovf, want.last)});
      end
    end
  end

  // cycles without any transfer on either channel
  always @(posedge clk) begin
    if (rst || (chr_if.valid && chr_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    int r;
    rst = 1'b1;

    // noise while idle, header mismatch and restart, empty fields, a comma indicator,
    // extreme byte values in a text field, indicator and status
    rx_queue = '{8'h00, 8'hFF, CH_DOLLAR, CH_G, "X", CH_DOLLAR, CH_G, CH_P, CH_G, CH_L, CH_L,
                 CH_COMMA, CH_COMMA, CH_COMMA, CH_COMMA, 8'h00, CH_COMMA, 8'hFF, CH_COMMA,
                 CH_COMMA, 8'hFF};

    // longest burst, then a sentence that drops characters
    add_sentence(DEPTH, DEPTH, DEPTH, 0);
    add_sentence(DEPTH + 3, 2, DEPTH + 1, 0);
    while (rx_queue.size() < 150) begin
      r = $urandom_range(99);
      if (r < 75) begin
        add_sentence(pick_len(), pick_len(), pick_len(), 0);
      end else if (r < 90) begin
        add_sentence(pick_len(), pick_len(), pick_len(), $urandom_range(3, 1));
      end else begin
        repeat ($urandom_range(5, 1)) rx_queue.push_back(8'($urandom_range(255)));
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while ((rx_queue.size() > 0 || chr_if.valid || tagged_due.size() > 0) &&
           quiet_cycles < QUIET_LIMIT);

    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, tagged_due.size());
      $display("Mismatches found");
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk);
      if (tagged_due.size() > 0)
        report($sformatf("%0d expected results never arrived", tagged_due.size()));
      if (mismatches == 0)
        $display("No mismatches found");
      else
        $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
